FILE: design/sgb_pkg.sv
// shared types, constants and glyph font for the scaled glyph blitter
`timescale 1ns / 1ps

package sgb_pkg;

    localparam int GLYPH_SIDE  = 5;
    localparam int GLYPH_COUNT = 36;
    localparam int MAX_SCALE   = 16;

    // command codes on the input channel
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // character codes
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [5:0] DIGIT_BASE = 6'd26;

    // register indexes on the configuration port
    localparam logic [2:0] REG_BASE   = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_PITCH  = 3'd3;
    localparam logic [2:0] REG_BPP    = 3'd4;

    // register reset values
    localparam logic [47:0] RST_BASE   = 48'd0;
    localparam logic [13:0] RST_WIDTH  = 14'd640;
    localparam logic [13:0] RST_HEIGHT = 14'd480;
    localparam logic [15:0] RST_PITCH  = 16'd2560;
    localparam logic [3:0]  RST_BPP    = 4'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic [47:0] base;
        logic [13:0] width;
        logic [13:0] height;
        logic [15:0] pitch;
        logic [3:0]  bpp;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic mul;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_step;
        logic known;
        logic busy;
        logic out_free;
    } t_stat;

    // five row masks per glyph, top row in the high bits, bit 4 is the left column
    typedef logic [24:0] t_glyph;

    localparam t_glyph GLYPH_ROM [GLYPH_COUNT] = '{
        {5'h04, 5'h0A, 5'h1F, 5'h11, 5'h11}, {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E},
        {5'h0E, 5'h11, 5'h10, 5'h11, 5'h0E}, {5'h1C, 5'h12, 5'h11, 5'h12, 5'h1C},
        {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h1F}, {5'h1F, 5'h10, 5'h1C, 5'h10, 5'h10},
        {5'h0E, 5'h10, 5'h13, 5'h11, 5'h0E}, {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
        {5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F}, {5'h07, 5'h02, 5'h02, 5'h12, 5'h0C},
        {5'h11, 5'h12, 5'h1C, 5'h12, 5'h11}, {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11}, {5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
        {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
        {5'h0E, 5'h11, 5'h11, 5'h12, 5'h0D}, {5'h1E, 5'h11, 5'h1E, 5'h14, 5'h13},
        {5'h0E, 5'h10, 5'h0E, 5'h01, 5'h1E}, {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04},
        {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, {5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11}, {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
        {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04}, {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F},
        {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, {5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E},
        {5'h0E, 5'h11, 5'h04, 5'h08, 5'h1F}, {5'h0E, 5'h11, 5'h06, 5'h11, 5'h0E},
        {5'h12, 5'h12, 5'h1F, 5'h02, 5'h02}, {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E},
        {5'h0E, 5'h10, 5'h1E, 5'h11, 5'h0E}, {5'h1F, 5'h02, 5'h04, 5'h08, 5'h10},
        {5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E}, {5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E}
    };

    // one row mask of one glyph
    function automatic logic [4:0] glyph_row(input logic [5:0] num, input logic [2:0] row);
        t_glyph g;
        logic [4:0] r;
        g = '0;
        if (num < 6'(GLYPH_COUNT)) begin
            g = GLYPH_ROM[num];
        end
        unique case (row)
            3'd0:    r = g[24:20];
            3'd1:    r = g[19:15];
            3'd2:    r = g[14:10];
            3'd3:    r = g[9:5];
            3'd4:    r = g[4:0];
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/sgb_regs.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module sgb_regs import sgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[5:3];
    assign o_cfg  = r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base   <= RST_BASE;
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.pitch  <= RST_PITCH;
            r_cfg.bpp    <= RST_BPP;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BASE:   r_cfg.base   <= pwdata[47:0];
                REG_WIDTH:  r_cfg.width  <= pwdata[13:0];
                REG_HEIGHT: r_cfg.height <= pwdata[13:0];
                REG_PITCH:  r_cfg.pitch  <= pwdata[15:0];
                REG_BPP:    r_cfg.bpp    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_BASE:   prdata = {16'd0, r_cfg.base};
            REG_WIDTH:  prdata = {50'd0, r_cfg.width};
            REG_HEIGHT: prdata = {50'd0, r_cfg.height};
            REG_PITCH:  prdata = {48'd0, r_cfg.pitch};
            REG_BPP:    prdata = {60'd0, r_cfg.bpp};
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: design/sgb_ctrl.sv
// controller state machine sequencing accept, multiply and result load
`timescale 1ns / 1ps

module sgb_ctrl import sgb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (!i_stat.is_step) begin
                        o_cmd.start = 1'b1;
                        if (!i_stat.known) begin
                            n_state = ST_SUM;
                        end
                    end else if (i_stat.busy) begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // the product stage is always followed by the sum state in the next cycle
    a_mul_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL |=> r_state == ST_SUM)
        else $error("multiply stage did not advance");

    // a step is only taken while a glyph is running
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> i_stat.busy && o_ready)
        else $error("step issued without a running glyph");

    // a result waits in the sum state until the output register frees up
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && !i_stat.out_free) |=> r_state == ST_SUM)
        else $error("result dropped while output register full");

endmodule

FILE: design/sgb_datapath.sv
// glyph walk counters, clipping, address arithmetic and output register
`timescale 1ns / 1ps

module sgb_datapath import sgb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  t_cfg               i_cfg,
    input  logic               i_command,
    input  logic [7:0]         i_glyph_char,
    input  logic signed [15:0] i_origin_x,
    input  logic signed [15:0] i_origin_y,
    input  logic [4:0]         i_scale,
    input  logic [31:0]        i_color,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_write_enable,
    output logic [47:0]        o_byte_address,
    output logic [31:0]        o_pixel_value,
    output logic               o_last
);

    // glyph state
    logic               r_busy;
    logic [5:0]         r_glyph;
    logic [2:0]         r_cell_row;
    logic [2:0]         r_cell_col;
    logic [3:0]         r_sub_row;
    logic [3:0]         r_sub_col;
    logic signed [15:0] r_org_x;
    logic signed [15:0] r_org_y;
    logic [4:0]         r_scale;
    logic [31:0]        r_color;

    // per-position pipeline
    logic        r_hit;
    logic        r_last;
    logic [13:0] r_px;
    logic [13:0] r_py;
    logic [29:0] r_prod_y;
    logic [17:0] r_prod_x;

    // output register
    logic        r_out_valid;
    logic        r_out_we;
    logic [47:0] r_out_addr;
    logic [31:0] r_out_pix;
    logic        r_out_last;

    logic        w_is_letter;
    logic        w_is_digit;
    logic        w_known;
    logic [5:0]  w_glyph_num;
    logic [4:0]  w_scale_sat;
    logic [7:0]  w_off_x;
    logic [7:0]  w_off_y;
    logic [16:0] w_px;
    logic [16:0] w_py;
    logic [4:0]  w_row_bits;
    logic [2:0]  w_bit_idx;
    logic        w_lit;
    logic        w_on_x;
    logic        w_on_y;
    logic        w_col_end;
    logic        w_row_end;
    logic        w_cell_col_end;
    logic        w_cell_row_end;
    logic [47:0] w_addr;

    // character to glyph number
    assign w_is_letter = (i_glyph_char >= CHAR_A) && (i_glyph_char <= CHAR_Z);
    assign w_is_digit  = (i_glyph_char >= CHAR_0) && (i_glyph_char <= CHAR_9);
    assign w_known     = w_is_letter || w_is_digit;
    assign w_glyph_num = w_is_letter ? 6'(i_glyph_char - CHAR_A)
                                     : 6'(DIGIT_BASE + 6'(i_glyph_char - CHAR_0));

    // scale clamp to one .. max
    always_comb begin
        if (i_scale == 5'd0) begin
            w_scale_sat = 5'd1;
        end else if (i_scale > 5'(MAX_SCALE)) begin
            w_scale_sat = 5'(MAX_SCALE);
        end else begin
            w_scale_sat = i_scale;
        end
    end

    // pixel position of the current sub-pixel
    assign w_off_x = 8'(r_cell_col) * 8'(r_scale) + 8'(r_sub_col);
    assign w_off_y = 8'(r_cell_row) * 8'(r_scale) + 8'(r_sub_row);
    assign w_px    = {r_org_x[15], r_org_x} + {9'd0, w_off_x};
    assign w_py    = {r_org_y[15], r_org_y} + {9'd0, w_off_y};
    assign w_on_x  = !w_px[16] && (w_px[15:0] < {2'd0, i_cfg.width});
    assign w_on_y  = !w_py[16] && (w_py[15:0] < {2'd0, i_cfg.height});

    // font lookup
    assign w_row_bits = glyph_row(r_glyph, r_cell_row);
    assign w_bit_idx  = 3'(GLYPH_SIDE - 1) - r_cell_col;
    assign w_lit      = w_row_bits[w_bit_idx];

    // walk order: dx innermost, then dy, cell column, cell row
    assign w_col_end      = (5'(r_sub_col) + 5'd1) >= r_scale;
    assign w_row_end      = (5'(r_sub_row) + 5'd1) >= r_scale;
    assign w_cell_col_end = r_cell_col == 3'(GLYPH_SIDE - 1);
    assign w_cell_row_end = r_cell_row == 3'(GLYPH_SIDE - 1);

    // glyph state update on start and step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_glyph    <= '0;
            r_cell_row <= '0;
            r_cell_col <= '0;
            r_sub_row  <= '0;
            r_sub_col  <= '0;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_scale    <= 5'd1;
            r_color    <= '0;
        end else if (i_cmd.start) begin
            r_busy     <= w_known;
            if (w_known) begin
                r_glyph <= w_glyph_num;
            end
            r_cell_row <= '0;
            r_cell_col <= '0;
            r_sub_row  <= '0;
            r_sub_col  <= '0;
            r_org_x    <= i_origin_x;
            r_org_y    <= i_origin_y;
            r_scale    <= w_scale_sat;
            r_color    <= i_color;
        end else if (i_cmd.step) begin
            if (!w_col_end) begin
                r_sub_col <= r_sub_col + 4'd1;
            end else begin
                r_sub_col <= '0;
                if (!w_row_end) begin
                    r_sub_row <= r_sub_row + 4'd1;
                end else begin
                    r_sub_row <= '0;
                    if (!w_cell_col_end) begin
                        r_cell_col <= r_cell_col + 3'd1;
                    end else begin
                        r_cell_col <= '0;
                        if (!w_cell_row_end) begin
                            r_cell_row <= r_cell_row + 3'd1;
                        end else begin
                            r_cell_row <= '0;
                            r_busy     <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    // position stage: hit and last flags, clipped coordinates
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hit  <= 1'b0;
            r_last <= !w_known;
        end else if (i_cmd.step) begin
            r_hit  <= w_lit && w_on_x && w_on_y;
            r_last <= w_col_end && w_row_end && w_cell_col_end && w_cell_row_end;
            r_px   <= w_px[13:0];
            r_py   <= w_py[13:0];
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_y <= 30'(r_py) * 30'(i_cfg.pitch);
            r_prod_x <= 18'(r_px) * 18'(i_cfg.bpp);
        end
    end

    // final address, wraps modulo the address width
    assign w_addr = i_cfg.base + 48'(r_prod_y) + 48'(r_prod_x);

    // output register, refilled while the previous result is being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_we   <= r_hit;
            r_out_addr <= r_hit ? w_addr : '0;
            r_out_pix  <= r_hit ? r_color : '0;
            r_out_last <= r_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_write_enable = r_out_we;
    assign o_byte_address = r_out_addr;
    assign o_pixel_value  = r_out_pix;
    assign o_last         = r_out_last;

    assign o_stat.is_step  = i_command == CMD_STEP;
    assign o_stat.known    = w_known;
    assign o_stat.busy     = r_busy;
    assign o_stat.out_free = !r_out_valid || i_ready;

    // walk counters stay inside the glyph and the scale stays clamped
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cell_row < 3'(GLYPH_SIDE) && r_cell_col < 3'(GLYPH_SIDE) &&
        5'(r_sub_row) < r_scale && 5'(r_sub_col) < r_scale &&
        r_scale != 5'd0 && r_scale <= 5'(MAX_SCALE))
        else $error("glyph walk counters out of range");

    // a glyph-ending result leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_last) |-> !r_busy)
        else $error("last result while glyph still running");

    // a non-write result carries zero address and data
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_hit) |=>
        (o_valid && !o_write_enable && o_byte_address == '0 && o_pixel_value == '0))
        else $error("non-write result with nonzero payload");

endmodule

FILE: design/scaled_glyph_blitter_core.sv
// top level of the scaled 5x5 glyph blitter
`timescale 1ns / 1ps
//
// Draws one 5x5 glyph (A-Z, 0-9) magnified by scale into a linear framebuffer.
// Input channel (i_valid/o_ready): a start transfer loads character, origin,
// scale and color; each step transfer visits the next sub-pixel, dx innermost.
// Output channel (o_valid/i_ready): one result per step while a glyph runs,
// a pixel write or a no-write for unlit or clipped positions; last marks the
// final position. A start with an unknown character yields one no-write
// result with last set. Starts of known glyphs and steps while idle give none.
// Sequence: a step's position and hit flags are registered at the transfer,
// the product in the multiply state, and the address add feeds the output
// register, loaded in the sum state once free; no new item is taken until then.
// Known starts and idle steps leave the block idle; unknown-character starts wait in the sum state.
// A stalled receiver holds the result in the output register; the next item
// is still taken and waits in the add stage until the register frees up.
// Reset clears the walk and the output register and loads register defaults.
// Registers sit at byte address 8*index on the APB-style port, 64-bit data.
//

module scaled_glyph_blitter_core import sgb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [7:0]         i_glyph_char,
    input  logic signed [15:0] i_origin_x,
    input  logic signed [15:0] i_origin_y,
    input  logic [4:0]         i_scale,
    input  logic [31:0]        i_color,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_write_enable,
    output logic [47:0]        o_byte_address,
    output logic [31:0]        o_pixel_value,
    output logic               o_last
);

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    // configuration registers
    sgb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencing
    sgb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // walk, clip and address arithmetic
    sgb_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg          (w_cfg),
        .i_command      (i_command),
        .i_glyph_char   (i_glyph_char),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_scale        (i_scale),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_enable (o_write_enable),
        .o_byte_address (o_byte_address),
        .o_pixel_value  (o_pixel_value),
        .o_last         (o_last)
    );

endmodule
